// File: rtl/fer_pkg.sv
// ----------------------------------------------------------------------------
// fer_pkg
// Shared types and constants of the edge-replicating smoothing FIR filter.
// ----------------------------------------------------------------------------
package fer_pkg;

  localparam int TAPS_DEF        = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // Coefficient register file: fixed count, unsigned Q1.15
  localparam int NCOEF      = 7;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 3;
  localparam int FRAC       = 15;
  localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(32768);
  localparam int CENTER_IDX = 3;

  // Guard bits for a sum of up to seven products
  localparam int ACC_GUARD = 3;

  // APB port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic fill;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/fir_filter_edge_replicate.sv
// ----------------------------------------------------------------------------
// fir_filter_edge_replicate
// Smoothing FIR over blocks of signed samples with edge replication at both
// block boundaries. Window samples live in a chain of tap cells; partial sums
// ripple through the chain one cell per cycle.
// ----------------------------------------------------------------------------
// Path: a result moves from the window registers through the product and
//   partial-sum registers of all TAPS cells into the output register.
// Throughput: a sample that owes no result leaves the sequencer idle; one
//   that completes a window stalls the input until its sum has walked all
//   TAPS cells and is loaded; a block end adds LOOK edge-replicating shifts.
// Reset: synchronous, clears control state and loads coef_3 = 1.0 (others 0).
// ----------------------------------------------------------------------------
module fir_filter_edge_replicate #(
  parameter int TAPS        = fer_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fer_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic                               block_end,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      smoothed,
  output logic                               smoothed_last,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fer_pkg::PADDR_W-1:0]        paddr,
  input  logic [fer_pkg::PDATA_W-1:0]        pwdata,
  output logic [fer_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  // Samples still owed when the block ends
  localparam int LOOK     = TAPS - 1 - TAPS / 2;
  localparam int CNT_W    = $clog2(LOOK + 2);
  // Cycles from a window change until the last cell's partial sum is final
  localparam int CALC_CYC = TAPS + 1;
  localparam int CALC_W   = $clog2(CALC_CYC + 1);
  localparam int ACC_W    = SAMPLE_BITS + fer_pkg::COEF_W + 1 + fer_pkg::ACC_GUARD;
  localparam int Q_W      = ACC_W - fer_pkg::FRAC;
  localparam logic signed [Q_W-1:0] QMAX = Q_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0] QMIN = -QMAX - Q_W'(1);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 <<< (fer_pkg::FRAC - 1));

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  logic [fer_pkg::COEF_W-1:0]     coef [fer_pkg::NCOEF];
  logic [fer_pkg::COEF_IDX_W-1:0] widx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign widx   = paddr[fer_pkg::COEF_IDX_W+1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fer_pkg::NCOEF; i++) begin
        coef[i] <= '0;
      end
      coef[fer_pkg::CENTER_IDX] <= fer_pkg::COEF_UNITY;
    end else if (wr_en && (widx < fer_pkg::COEF_IDX_W'(fer_pkg::NCOEF))) begin
      // drop writes beyond the last coefficient
      coef[widx] <= pwdata[fer_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (widx < fer_pkg::COEF_IDX_W'(fer_pkg::NCOEF)) begin
      prdata = fer_pkg::PDATA_W'(coef[widx]);
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  fer_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  pending;      // outputs owed within the running block
  logic              mid_block;
  logic [CNT_W-1:0]  owed;         // outputs owed at block end
  logic [CNT_W-1:0]  flush_left;   // edge-replicating shifts still to do
  logic [CALC_W-1:0] cnt;
  logic              last_pend;    // the result in flight closes the block
  logic signed [SAMPLE_BITS-1:0] s_hold;

  logic              accept;
  logic [CNT_W-1:0]  pend_eff;
  logic [CNT_W-1:0]  pend_new;
  logic              emit_now;
  logic              emit_shift;
  logic              calc_done;
  logic              out_free;
  logic              load_out;
  fer_pkg::cell_ctl_t ctl;
  logic signed [SAMPLE_BITS-1:0] smp;

  assign accept     = in_valid && !in_stall;
  assign pend_eff   = mid_block ? pending : '0;
  assign emit_now   = (pend_eff == CNT_W'(LOOK));
  assign pend_new   = emit_now ? pend_eff : pend_eff + CNT_W'(1);
  // during the flush, the last `owed` shifts each yield a result
  assign emit_shift = (flush_left <= owed);
  assign calc_done  = (cnt == CALC_W'(CALC_CYC));
  assign out_free   = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fer_pkg::ST_IDLE: begin
        if (accept) begin
          if (emit_now) begin
            state_next = fer_pkg::ST_CALC;
          end else if (block_end) begin
            state_next = fer_pkg::ST_SHIFT;
          end
        end
      end
      fer_pkg::ST_SHIFT: begin
        if (emit_shift) begin
          state_next = fer_pkg::ST_CALC;
        end
      end
      fer_pkg::ST_CALC: begin
        if (calc_done && out_free) begin
          state_next = (flush_left != '0) ? fer_pkg::ST_SHIFT : fer_pkg::ST_IDLE;
        end
      end
      default: state_next = fer_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ctl       = '0;
    load_out  = 1'b0;
    smp       = s_hold;
    unique case (state)
      fer_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        smp       = sample;
        // first beat of a block fills the whole window (left edge)
        ctl.fill  = in_valid && !mid_block;
        ctl.shift = in_valid && mid_block;
      end
      fer_pkg::ST_SHIFT: begin
        // replicate the right edge
        ctl.shift = 1'b1;
      end
      fer_pkg::ST_CALC: begin
        load_out = calc_done && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fer_pkg::ST_IDLE;
      pending    <= '0;
      mid_block  <= 1'b0;
      owed       <= '0;
      flush_left <= '0;
      cnt        <= '0;
      last_pend  <= 1'b0;
    end else begin
      state <= state_next;

      if (state != fer_pkg::ST_CALC) begin
        cnt <= '0;
      end else if (!calc_done) begin
        cnt <= cnt + CALC_W'(1);
      end

      if (accept) begin
        pending    <= block_end ? '0 : pend_new;
        mid_block  <= !block_end;
        owed       <= pend_new;
        flush_left <= block_end ? CNT_W'(LOOK) : '0;
        last_pend  <= block_end && (LOOK == 0);
      end

      if (state == fer_pkg::ST_SHIFT) begin
        flush_left <= flush_left - CNT_W'(1);
        last_pend  <= (flush_left == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_hold <= sample;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: samples move toward cell 0, partial sums toward the last cell
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] win_a  [TAPS];
  logic signed [ACC_W-1:0]       psum_a [TAPS+1];

  assign psum_a[0] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nbr;
    if (k == TAPS - 1) begin : g_head
      assign nbr = smp;
    end else begin : g_body
      assign nbr = win_a[k+1];
    end

    fer_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .smp      (smp),
      .nbr      (nbr),
      .coef     (coef[k]),
      .psum_in  (psum_a[k]),
      .win      (win_a[k]),
      .psum_out (psum_a[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Round half up, drop the fraction, saturate
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]       rnd;
  logic signed [Q_W-1:0]         q;
  logic signed [SAMPLE_BITS-1:0] sat;

  always_comb begin
    rnd = psum_a[TAPS] + HALF_LSB;
    q   = rnd[ACC_W-1:fer_pkg::FRAC];
    if (q > QMAX) begin
      sat = QMAX[SAMPLE_BITS-1:0];
    end else if (q < QMIN) begin
      sat = QMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  // Output register: hold while stalled, advance when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      smoothed      <= sat;
      smoothed_last <= last_pend;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(LOOK))
    else $error("owed count exceeds the look-ahead");

  a_flush_owed: assert property (@(posedge clk) disable iff (rst)
    state == fer_pkg::ST_SHIFT |-> (owed != '0) && (flush_left != '0))
    else $error("flush shift with nothing owed");

  a_calc_cnt: assert property (@(posedge clk) disable iff (rst)
    state == fer_pkg::ST_CALC |-> cnt <= CALC_W'(CALC_CYC))
    else $error("partial sum wait counter overran");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    load_out && last_pend |-> !mid_block && (flush_left == '0))
    else $error("last beat of a block issued while the block is still open");

endmodule

// File: rtl/fer_cell.sv
// ----------------------------------------------------------------------------
// fer_cell
// One tap of the filter: holds one window sample, forms its weighted product
// and adds it to the partial sum that walks down the chain.
// ----------------------------------------------------------------------------
module fer_cell #(
  parameter int SAMPLE_BITS = fer_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  fer_pkg::cell_ctl_t        ctl,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  input  logic signed [SAMPLE_BITS-1:0] nbr,
  input  logic [fer_pkg::COEF_W-1:0]    coef,
  input  logic signed [SAMPLE_BITS+fer_pkg::COEF_W+1+fer_pkg::ACC_GUARD-1:0] psum_in,
  output logic signed [SAMPLE_BITS-1:0] win,
  output logic signed [SAMPLE_BITS+fer_pkg::COEF_W+1+fer_pkg::ACC_GUARD-1:0] psum_out
);

  localparam int PROD_W = SAMPLE_BITS + fer_pkg::COEF_W + 1;
  localparam int ACC_W  = PROD_W + fer_pkg::ACC_GUARD;

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      win <= smp;
    end else if (ctl.shift) begin
      win <= nbr;
    end
    prod     <= $signed({1'b0, coef}) * win;
    psum_out <= psum_in + ACC_W'(prod);
  end

endmodule

// File: dv/fir_filter_edge_replicate_tb.sv
// ----------------------------------------------------------------------------
// fir_filter_edge_replicate_tb
// Self-checking bench for the edge-replicating smoothing FIR. Blocks of signed
// samples are sent through the valid/stall input channel, tap weights are
// loaded over the APB port, and every filtered beat is compared against an
// in-bench predictor of the windowed, rounded and saturated sum.
// ----------------------------------------------------------------------------
module fir_filter_edge_replicate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = fer_pkg::TAPS_DEF;
  localparam int SW   = fer_pkg::SAMPLE_BITS_DEF;
  localparam int HALF = TAPS / 2;
  // outputs trail the input by this many samples
  localparam int LOOK = TAPS - 1 - HALF;

  // first register index with nothing behind it; writes there are dropped
  localparam int REG_BEYOND = fer_pkg::NCOEF;

  // worst block-end flush plus some margin, in cycles
  localparam int SETTLE_CYCLES = (1 + LOOK) * (TAPS + 3) + 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 4;
  localparam int PHASE_BEATS   = 50;
  localparam longint LIMIT_CYCLES = 400000;
  localparam int PRINT_CAP     = 40;

  localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  // binomial smoothing kernel, scaled so the weights sum to exactly 1.0
  localparam int BINOMIAL [fer_pkg::NCOEF] = '{1, 6, 15, 20, 15, 6, 1};
  localparam int BINOMIAL_SCALE   = 512;

  typedef enum int {
    KERNEL_RANDOM,
    KERNEL_ONE_HOT,
    KERNEL_WIDE,
    KERNEL_BINOMIAL
  } kernel_t;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 last;
  } smoothed_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input is driven to a known value from time zero
  // --------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic signed [SW-1:0]          sample    = '0;
  logic                          block_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SW-1:0]          smoothed;
  logic                          smoothed_last;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [fer_pkg::PADDR_W-1:0]   paddr     = '0;
  logic [fer_pkg::PDATA_W-1:0]   pwdata    = '0;
  logic [fer_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  fir_filter_edge_replicate #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SW)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .smoothed      (smoothed),
    .smoothed_last (smoothed_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: tap weights, sample window and block bookkeeping
  // --------------------------------------------------------------------------
  logic [fer_pkg::COEF_W-1:0] coef_model [fer_pkg::NCOEF];
  logic signed [SW-1:0]       win_model  [TAPS];
  int                         owed;
  bit                         in_block;
  smoothed_t                  expected_smoothed [$];

  int     mismatches = 0;
  longint cycles     = 0;

  // sender and receiver pacing controls
  bit sender_calm = 1'b0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;
  int run_left    = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] ERROR smoothed: %s", $time, what);
  endtask

  // Compute one filtered value from the current window and queue it.
  function automatic void emit_smoothed(input bit last);
    longint    acc;
    longint    q;
    smoothed_t r;
    acc = 0;
    for (int j = 0; j < TAPS; j++)
      acc += longint'(coef_model[j]) * longint'(win_model[j]);
    // round half up, then floor-shift back to sample scale
    q = (acc + (longint'(1) << (fer_pkg::FRAC - 1))) >>> fer_pkg::FRAC;
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    r.value = q[SW-1:0];
    r.last  = last;
    expected_smoothed.push_back(r);
  endfunction

  function automatic void shift_window(input logic signed [SW-1:0] s);
    for (int k = 0; k + 1 < TAPS; k++)
      win_model[k] = win_model[k + 1];
    win_model[TAPS-1] = s;
  endfunction

  // Advance the predictor by one accepted input beat.
  function automatic void predict_smoothed(input logic signed [SW-1:0] s, input bit last);
    int n;
    if (!in_block) begin
      // first sample of a block replicates the left edge across the window
      for (int k = 0; k < TAPS; k++)
        win_model[k] = s;
      owed = 0;
    end else begin
      shift_window(s);
    end

    if (owed + 1 > LOOK) begin
      emit_smoothed(last && (LOOK == 0));
    end else begin
      owed++;
    end

    if (last) begin
      // right edge: push the last sample in again until every owed output is out
      n = owed;
      for (int k = 0; k < LOOK - n; k++)
        shift_window(s);
      for (int k = 0; k < n; k++) begin
        shift_window(s);
        emit_smoothed(k + 1 == n);
      end
      owed     = 0;
      in_block = 1'b0;
    end else begin
      in_block = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: check every accepted beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    smoothed_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_smoothed.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value %0d last %0b",
                                  smoothed, smoothed_last));
      end else begin
        want = expected_smoothed.pop_front();
        if (smoothed !== want.value)
          report_mismatch($sformatf("value got %0d want %0d", smoothed, want.value));
        if (smoothed_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b (value %0d)",
                                    smoothed_last, want.last, want.value));
      end
    end
  end

  // Receiver stall pattern. A hold request takes priority; stall stays high until
  // hold_left runs out, backing the filter up into its input. Otherwise alternate
  // short stalls, the odd long one, and calm stretches with no stall at all.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(9))
        0: begin
          run_left   = $urandom_range(150, 50);
          stall_left = 0;
        end
        1: begin
          run_left   = $urandom_range(8);
          stall_left = $urandom_range(40, 15);
        end
        default: begin
          run_left   = $urandom_range(6);
          stall_left = $urandom_range(3, 1);
        end
      endcase
    end
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("fir_filter_edge_replicate: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Offer one beat and hold it until accepted. Called and returns on a
  // falling edge; valid stays high on return so back-to-back beats need no
  // drop. The next gap or wait_idle lowers it.
  task automatic send_sample(input logic signed [SW-1:0] s, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    block_end <= last;
    do @(posedge clk); while (in_stall);
    predict_smoothed(s, last);
    @(negedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom_range(1) ? SW'(SMAX) : SW'(SMIN);
    if (r == 1) return SW'($urandom_range(512) - 256);
    return SW'($urandom);
  endfunction

  // Mostly short blocks; a few long ones keep the window fully interior.
  function automatic int pick_block_len();
    int r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(8, 1);
    if (r < 9) return $urandom_range(20, 9);
    return $urandom_range(40, 21);
  endfunction

  task automatic send_random_block(input int len);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), i == len - 1);
  endtask

  // Drop valid, drain every expected beat, then let the pipeline settle so a
  // register write cannot land on work in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_smoothed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic write_reg(input int idx, input logic [fer_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fer_pkg::PADDR_W'(4 * idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < fer_pkg::NCOEF) coef_model[idx] = data[fer_pkg::COEF_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_reg(input int idx, output logic [fer_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= fer_pkg::PADDR_W'(4 * idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_coefs();
    logic [fer_pkg::PDATA_W-1:0] got;
    for (int i = 0; i < fer_pkg::NCOEF; i++) begin
      read_reg(i, got);
      if (got[fer_pkg::COEF_W-1:0] !== coef_model[i])
        report_mismatch($sformatf("coef_%0d reads %0h want %0h",
                                  i, got[fer_pkg::COEF_W-1:0], coef_model[i]));
    end
  endtask

  // Load all taps; the upper bus bits carry junk that the register must drop.
  task automatic load_kernel(input kernel_t kind);
    logic [fer_pkg::PDATA_W-1:0] word;
    int                          hot;
    hot = $urandom_range(TAPS - 1);
    for (int i = 0; i < fer_pkg::NCOEF; i++) begin
      word = $urandom;
      case (kind)
        KERNEL_RANDOM:
          word[fer_pkg::COEF_W-1:0] = fer_pkg::COEF_W'($urandom_range(32768));
        KERNEL_ONE_HOT:
          word[fer_pkg::COEF_W-1:0] = (i == hot) ? fer_pkg::COEF_UNITY : '0;
        KERNEL_WIDE:
          word[fer_pkg::COEF_W-1:0] = fer_pkg::COEF_W'($urandom);
        default:
          word[fer_pkg::COEF_W-1:0] = fer_pkg::COEF_W'(BINOMIAL[i] * BINOMIAL_SCALE);
      endcase
      write_reg(i, word);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset weights give pass-through. Cover single-sample blocks, blocks
  // shorter than the look-ahead, and sample extremes and bit patterns.
  task automatic test_passthrough();
    send_sample(SW'(SMAX), 1'b1);
    send_sample(SW'(SMIN), 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1,   1'b0);
    send_sample(16'sd1,    1'b1);
    send_sample(16'sd100,  1'b0);
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd300,  1'b0);
    send_sample(-16'sd400, 1'b1);
    send_sample(SW'(SMAX), 1'b0);
    send_sample(SW'(SMIN), 1'b0);
    send_sample(SW'(SMAX), 1'b0);
    send_sample(SW'(SMIN), 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    wait_idle();
  endtask

  // Walk every weight register through its extremes with read-back, poke the
  // unused address past the last tap, then smooth a ramp with a real kernel.
  task automatic test_registers();
    logic [fer_pkg::COEF_W-1:0]  probe [3] = '{16'hFFFF, fer_pkg::COEF_UNITY, 16'h0000};
    logic [fer_pkg::PDATA_W-1:0] word;
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < fer_pkg::NCOEF; i++) begin
        word = $urandom;
        word[fer_pkg::COEF_W-1:0] = probe[v];
        write_reg(i, word);
      end
      check_coefs();
    end
    write_reg(REG_BEYOND, $urandom);
    check_coefs();

    load_kernel(KERNEL_BINOMIAL);
    check_coefs();
    send_sample(SW'(SMIN),  1'b0);
    send_sample(-16'sd16384, 1'b0);
    send_sample(16'sd0,      1'b0);
    send_sample(16'sd16384,  1'b0);
    send_sample(SW'(SMAX),  1'b1);
    wait_idle();
  endtask

  // Out-of-range weights on every tap drive the sum past both rails.
  task automatic test_saturation();
    for (int i = 0; i < fer_pkg::NCOEF; i++)
      write_reg(i, fer_pkg::PDATA_W'({fer_pkg::COEF_W{1'b1}}));
    send_sample(SW'(SMAX), 1'b0);
    send_sample(SW'(SMAX), 1'b0);
    send_sample(SW'(SMIN), 1'b0);
    send_sample(SW'(SMIN), 1'b1);
    wait_idle();
  endtask

  // Random kernels per phase, random well-formed blocks within each phase.
  task automatic test_random_phases();
    int beats;
    int len;
    for (int p = 0; p < PHASES; p++) begin
      load_kernel(kernel_t'($urandom_range(KERNEL_BINOMIAL)));
      beats = 0;
      while (beats < PHASE_BEATS) begin
        len         = pick_block_len();
        sender_calm = ($urandom_range(4) == 0);
        send_random_block(len);
        beats += len;
      end
      sender_calm = 1'b0;
      wait_idle();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // beats back to back, so the filter fills and stalls its input.
  task automatic test_backpressure();
    load_kernel(KERNEL_BINOMIAL);
    hold_req    = 1'b1;
    sender_calm = 1'b1;
    for (int b = 0; b < 3; b++)
      send_random_block(12);
    sender_calm = 1'b0;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < fer_pkg::NCOEF; i++)
      coef_model[i] = '0;
    coef_model[fer_pkg::CENTER_IDX] = fer_pkg::COEF_UNITY;
    for (int k = 0; k < TAPS; k++)
      win_model[k] = '0;
    owed     = 0;
    in_block = 1'b0;

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_passthrough();
    test_registers();
    test_saturation();
    test_random_phases();
    test_backpressure();

    if (mismatches == 0) begin
      $display("fir_filter_edge_replicate: match");
    end else begin
      $display("fir_filter_edge_replicate: mismatch");
    end
    $finish;
  end

endmodule
